FILE: sv/tmcw_pkg.sv
package tmcw_pkg;

	// Field widths of the request and result channels.
	localparam int OP_W       = 3;
	localparam int CHAR_W     = 8;
	localparam int COLUMN_W   = 7;
	localparam int ROW_W      = 5;
	localparam int COLOR_W    = 4;
	localparam int CELL_W     = 16;

	// Configuration register widths and port shape.
	localparam int COLS_W     = 8;
	localparam int ROWS_W     = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Default screen store geometry.
	localparam int MAX_COLUMNS_DEF = 128;
	localparam int MAX_ROWS_DEF    = 32;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_PUT_CURSOR = 3'd0;
	localparam logic [OP_W-1:0] OP_PUT_CELL   = 3'd1;
	localparam logic [OP_W-1:0] OP_SET_CURSOR = 3'd2;
	localparam logic [OP_W-1:0] OP_SET_COLOR  = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;
	localparam logic [OP_W-1:0] OP_READ_CELL  = 3'd5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP_H  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP_V  = 2'd3;

	// Reset values.
	localparam logic [COLS_W-1:0]   COLUMNS_RST = 8'd80;
	localparam logic [ROWS_W-1:0]   ROWS_RST    = 6'd25;
	localparam logic                WRAP_H_RST  = 1'b1;
	localparam logic                WRAP_V_RST  = 1'b0;
	localparam logic [2*COLOR_W-1:0] COLOR_RST  = 8'h07;
	localparam logic [CHAR_W-1:0]   SPACE_CODE  = 8'h20;
	localparam logic [CELL_W-1:0]   CELL_RST    = 16'h0720;
	localparam logic [CELL_W-1:0]   LOW_BYTE_MASK = 16'b0000000011111111;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic read_load;
		logic sweep_step;
		logic init_step;
	} cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic out_free;
		logic needs_read;
		logic needs_sweep;
		logic sweep_last;
		logic init_last;
	} stat_t;

endpackage

FILE: sv/tmcw_if.sv
interface tmcw_item_if import tmcw_pkg::*;;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [CHAR_W-1:0]   char_code;
	logic [COLUMN_W-1:0] column;
	logic [ROW_W-1:0]    row;
	logic [COLOR_W-1:0]  foreground;
	logic [COLOR_W-1:0]  background;
	logic                move_cursor;
	logic                clear_screen;

	modport source (output valid, op, char_code, column, row, foreground, background,
		move_cursor, clear_screen, input ready);
	modport sink (input valid, op, char_code, column, row, foreground, background,
		move_cursor, clear_screen, output ready);
endinterface

interface tmcw_result_if import tmcw_pkg::*;;
	logic                valid;
	logic                ready;
	logic                status;
	logic [COLUMN_W-1:0] cursor_column;
	logic [ROW_W-1:0]    cursor_row;
	logic [CELL_W-1:0]   cell_value;

	modport source (output valid, status, cursor_column, cursor_row, cell_value,
		input ready);
	modport sink (input valid, status, cursor_column, cursor_row, cell_value,
		output ready);
endinterface

FILE: sv/text_mode_console_writer_unit.sv
// Text-mode console writer. The block holds a screen store of 16-bit cells
// (character in the low byte, color in the high byte, color = fg | bg << 4),
// a current color and a cursor, and executes one operation per request:
// put at cursor, put at cell, set cursor, set color (then clear or recolor),
// clear, and read cell. Every request returns exactly one result with a
// status, the cursor after the operation and, for a read, the cell. The
// block works on one request at a time. Put, set cursor and unused codes
// are captured, then executed; a read also waits on the store's registered
// read port. Clear and set color walk every cell of the current screen
// through the store's single write port; a recolor is a read-modify-write
// through the read and write ports. After reset the store is swept to
// spaces in color 0x07, one cell per cycle over all MAX_COLUMNS * MAX_ROWS
// cells (4096 with the default geometry); requests are held off during
// that pass, while configuration writes are taken at any time. A new
// request is taken while the previous result still waits in the output
// register; it is executed once that register frees up.
module text_mode_console_writer_unit import tmcw_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tmcw_item_if.sink             item,
	tmcw_result_if.source         result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Command and status buses between the sequencer and the datapath.
	cmd_t  cmd;
	stat_t stat;

	// The sequencer owns the request handshake and steps the datapath
	// through capture, execute, read wait and the cell sweeps.
	tmcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the configuration, the cursor, the color, the
	// screen store and the result register.
	tmcw_datapath #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.op            (item.op),
		.char_code     (item.char_code),
		.column        (item.column),
		.row           (item.row),
		.foreground    (item.foreground),
		.background    (item.background),
		.move_cursor   (item.move_cursor),
		.clear_screen  (item.clear_screen),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.status        (result.status),
		.cursor_column (result.cursor_column),
		.cursor_row    (result.cursor_row),
		.cell_value    (result.cell_value),
		.cmd           (cmd),
		.stat          (stat)
	);

`ifndef NO_ASSERTIONS
	// A request is only executed when its result has somewhere to go.
	a_exec_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> stat.out_free)
		else $error("request executed while the result register was occupied");

	// Only one request is in flight at a time.
	a_single_request: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("second request taken while one is in flight");

	// A valid read loads its result in the cycle after execution.
	a_read_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && stat.needs_read |=> cmd.read_load)
		else $error("read result not loaded after the store read");

	// No request is taken while the store is being cleared after reset.
	a_init_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init_step |-> !item.ready)
		else $error("request taken during the store clearing pass");
`endif

endmodule

FILE: sv/tmcw_ram.sv
module tmcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/tmcw_ctrl.sv
module tmcw_ctrl import tmcw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EXEC  = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_SWEEP = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			ST_INIT: begin
				cmd.init_step = 1'b1;
				if (stat.init_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// The request is executed only once its result has a free slot.
				if (stat.out_free) begin
					cmd.exec = 1'b1;
					if (stat.needs_sweep) begin
						state_d = ST_SWEEP;
					end else if (stat.needs_read) begin
						state_d = ST_READ;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_READ: begin
				cmd.read_load = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: sv/tmcw_datapath.sv
module tmcw_datapath import tmcw_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [OP_W-1:0]       op,
	input  logic [CHAR_W-1:0]     char_code,
	input  logic [COLUMN_W-1:0]   column,
	input  logic [ROW_W-1:0]      row,
	input  logic [COLOR_W-1:0]    foreground,
	input  logic [COLOR_W-1:0]    background,
	input  logic                  move_cursor,
	input  logic                  clear_screen,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  status,
	output logic [COLUMN_W-1:0]   cursor_column,
	output logic [ROW_W-1:0]      cursor_row,
	output logic [CELL_W-1:0]     cell_value,
	input  cmd_t                  cmd,
	output stat_t                 stat
);

	localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int NW    = $clog2(CELLS + 1);
	localparam int WW    = $clog2(MAX_COLUMNS + 1);
	localparam int HW    = $clog2(MAX_ROWS + 1);
	localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int XW    = (WW > COLUMN_W) ? WW : COLUMN_W;
	localparam int YW    = (HW > ROW_W) ? HW : ROW_W;
	localparam int XW1   = XW + 1;
	localparam int YW1   = YW + 1;
	localparam int PW    = YW + WW;
	localparam int SW    = ((PW > XW) ? PW : XW) + 1;
	localparam int CX    = COLS_W + 1;
	localparam int RX    = ROWS_W + 1;

	// Captured request.
	logic [OP_W-1:0]     op_q;
	logic [CHAR_W-1:0]   char_q;
	logic [COLUMN_W-1:0] column_q;
	logic [ROW_W-1:0]    row_q;
	logic [COLOR_W-1:0]  fg_q;
	logic [COLOR_W-1:0]  bg_q;
	logic                move_q;
	logic                clear_q;

	// Configuration and console state.
	logic [COLS_W-1:0]    cols_q;
	logic [ROWS_W-1:0]    rows_q;
	logic                 wrap_h_q;
	logic                 wrap_v_q;
	logic [2*COLOR_W-1:0] color_q;
	logic [CW-1:0]        cur_col_q;
	logic [RW-1:0]        cur_row_q;

	// Sweep and clearing pass.
	logic [NW-1:0] idx_q;
	logic [NW-1:0] idx_inc;
	logic [NW-1:0] n_q;
	logic          fill_q;
	logic          rd_s1;
	logic [NW-1:0] addr_s1;
	logic          issue;

	logic [WW-1:0] eff_w;
	logic [HW-1:0] eff_h;
	logic [XW-1:0] px;
	logic [YW-1:0] py;
	logic          in_range;
	logic [YW-1:0] mul_a;
	logic [PW-1:0] prod;
	logic [SW-1:0] addr_full;
	logic [AW-1:0] addr;
	logic [XW:0]   adv_c;
	logic [YW:0]   adv_r;
	logic [CW-1:0] nxt_col;
	logic [RW-1:0] nxt_row;
	logic          status_nxt;
	logic          sweep_op;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	logic ld_exec;
	logic ld_any;

	// Effective screen size: zero counts as one, oversize as the store limit.
	always_comb begin
		if (cols_q == '0) begin
			eff_w = WW'(1);
		end else if (CX'(cols_q) > CX'(MAX_COLUMNS)) begin
			eff_w = WW'(MAX_COLUMNS);
		end else begin
			eff_w = WW'(cols_q);
		end
		if (rows_q == '0) begin
			eff_h = HW'(1);
		end else if (RX'(rows_q) > RX'(MAX_ROWS)) begin
			eff_h = HW'(MAX_ROWS);
		end else begin
			eff_h = HW'(rows_q);
		end
	end

	always_comb begin
		if (op_q == OP_PUT_CURSOR) begin
			px = XW'(cur_col_q);
			py = YW'(cur_row_q);
		end else begin
			px = XW'(column_q);
			py = YW'(row_q);
		end
	end

	assign in_range  = (px < XW'(eff_w)) && (py < YW'(eff_h));
	assign sweep_op  = (op_q == OP_SET_COLOR) || (op_q == OP_CLEAR);

	// One multiplier serves both the cell address and the screen cell count.
	assign mul_a     = sweep_op ? YW'(eff_h) : py;
	assign prod      = PW'(mul_a) * PW'(eff_w);
	assign addr_full = SW'(prod) + SW'(px);
	assign addr      = addr_full[AW-1:0];

	// Cursor advance with horizontal then vertical wrap or clamp.
	always_comb begin
		adv_c = XW1'(px) + XW1'(1);
		adv_r = YW1'(py);
		if (adv_c >= XW1'(eff_w)) begin
			if (wrap_h_q) begin
				adv_c = '0;
				adv_r = adv_r + YW1'(1);
			end else begin
				adv_c = XW1'(eff_w) - XW1'(1);
			end
		end
		if (adv_r >= YW1'(eff_h)) begin
			if (wrap_v_q) begin
				adv_r = '0;
			end else begin
				adv_r = YW1'(eff_h) - YW1'(1);
			end
		end
	end

	always_comb begin
		nxt_col    = cur_col_q;
		nxt_row    = cur_row_q;
		status_nxt = 1'b0;
		unique case (op_q)
			OP_PUT_CURSOR: begin
				status_nxt = !in_range;
				if (in_range) begin
					nxt_col = CW'(adv_c);
					nxt_row = RW'(adv_r);
				end
			end
			OP_PUT_CELL: begin
				status_nxt = !in_range;
				if (in_range && move_q) begin
					nxt_col = CW'(adv_c);
					nxt_row = RW'(adv_r);
				end
			end
			OP_SET_CURSOR: begin
				status_nxt = !in_range;
				if (in_range) begin
					nxt_col = CW'(px);
					nxt_row = RW'(py);
				end
			end
			OP_SET_COLOR: begin
				if (clear_q) begin
					nxt_col = '0;
					nxt_row = '0;
				end
			end
			OP_CLEAR: begin
				nxt_col = '0;
				nxt_row = '0;
			end
			OP_READ_CELL: begin
				status_nxt = !in_range;
			end
			default: begin
				status_nxt = 1'b0;
			end
		endcase
	end

	assign idx_inc = idx_q + NW'(1);
	assign issue   = idx_q < n_q;

	assign stat.out_free    = !out_valid || out_ready;
	assign stat.needs_read  = (op_q == OP_READ_CELL) && in_range;
	assign stat.needs_sweep = sweep_op;
	assign stat.init_last   = idx_q == NW'(CELLS - 1);
	assign stat.sweep_last  = fill_q ? (idx_inc == n_q) : (rd_s1 && (addr_s1 + NW'(1) == n_q));

	// Store write and read port selection.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr;
		ram_wdata = {color_q, char_q};
		ram_raddr = addr;
		if (cmd.init_step) begin
			ram_we    = 1'b1;
			ram_waddr = idx_q[AW-1:0];
			ram_wdata = CELL_RST;
		end else if (cmd.sweep_step) begin
			ram_raddr = idx_q[AW-1:0];
			if (fill_q) begin
				ram_we    = 1'b1;
				ram_waddr = idx_q[AW-1:0];
				ram_wdata = {color_q, SPACE_CODE};
			end else begin
				ram_we    = rd_s1;
				ram_waddr = addr_s1[AW-1:0];
				ram_wdata = (ram_rdata & LOW_BYTE_MASK) | {color_q, CHAR_W'(0)};
			end
		end else if (cmd.exec) begin
			ram_we = in_range && ((op_q == OP_PUT_CURSOR) || (op_q == OP_PUT_CELL));
		end
	end

	tmcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= op;
			char_q   <= char_code;
			column_q <= column;
			row_q    <= row;
			fg_q     <= foreground;
			bg_q     <= background;
			move_q   <= move_cursor;
			clear_q  <= clear_screen;
		end
		if (cmd.exec) begin
			n_q    <= NW'(prod);
			fill_q <= (op_q == OP_CLEAR) || clear_q;
		end
		if (cmd.sweep_step) begin
			addr_s1 <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q   <= COLUMNS_RST;
			rows_q   <= ROWS_RST;
			wrap_h_q <= WRAP_H_RST;
			wrap_v_q <= WRAP_V_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COLUMNS: cols_q   <= cfg_data[COLS_W-1:0];
				CFG_ROWS:    rows_q   <= cfg_data[ROWS_W-1:0];
				CFG_WRAP_H:  wrap_h_q <= cfg_data[0];
				CFG_WRAP_V:  wrap_v_q <= cfg_data[0];
				default:     wrap_v_q <= wrap_v_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q   <= COLOR_RST;
			cur_col_q <= '0;
			cur_row_q <= '0;
			idx_q     <= '0;
			rd_s1     <= 1'b0;
		end else begin
			if (cmd.exec) begin
				cur_col_q <= nxt_col;
				cur_row_q <= nxt_row;
				if (op_q == OP_SET_COLOR) begin
					color_q <= {bg_q, fg_q};
				end
			end
			if (cmd.init_step) begin
				idx_q <= idx_inc;
			end else if (cmd.exec) begin
				idx_q <= '0;
			end else if (cmd.sweep_step && (fill_q || issue)) begin
				idx_q <= idx_inc;
			end
			if (cmd.exec) begin
				rd_s1 <= 1'b0;
			end else if (cmd.sweep_step) begin
				rd_s1 <= !fill_q && issue;
			end
		end
	end

	// Result register.
	assign ld_exec = cmd.exec && !stat.needs_sweep && !stat.needs_read;
	assign ld_any  = ld_exec || cmd.read_load || (cmd.sweep_step && stat.sweep_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ld_any) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_exec) begin
			status        <= status_nxt;
			cursor_column <= COLUMN_W'(nxt_col);
			cursor_row    <= ROW_W'(nxt_row);
			cell_value    <= '0;
		end else if (ld_any) begin
			status        <= 1'b0;
			cursor_column <= COLUMN_W'(cur_col_q);
			cursor_row    <= ROW_W'(cur_row_q);
			cell_value    <= cmd.read_load ? ram_rdata : CELL_W'(0);
		end
	end

endmodule
